### rtl/core/four_level_page_table_walker_assert.svh
// Assertion macros shared by the page table walker RTL.
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_ASSERT_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define PTW_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define PTW_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/ptw_pkg.sv
// Types, constants and helper functions of the page table walker.
`timescale 1ns / 1ps
`default_nettype none

package ptw_pkg;

	localparam int unsigned AddrW  = 64;
	localparam int unsigned VaW    = 48;
	localparam int unsigned PaW    = 52;
	localparam int unsigned IdxW   = 9;

	typedef enum logic {
		OP_START = 1'b0,
		OP_DATA  = 1'b1
	} opcode_t;

	typedef enum logic {
		KIND_READ = 1'b0,
		KIND_DONE = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		LVL_TOP    = 2'd0,
		LVL_SECOND = 2'd1,
		LVL_THIRD  = 2'd2,
		LVL_LAST   = 2'd3
	} level_t;

	localparam int unsigned PresentBit  = 0;
	localparam int unsigned PageSizeBit = 7;

	typedef struct packed {
		opcode_t             opcode;
		logic [AddrW-1:0]    root_base;
		logic [VaW-1:0]      virtual_address;
		logic [AddrW-1:0]    read_data;
	} walk_item_t;

	typedef struct packed {
		logic                busy;
		level_t              level;
		logic [VaW-1:0]      saved_address;
	} walk_state_t;

	typedef struct packed {
		kind_t               kind;
		logic [AddrW-1:0]    read_address;
		logic [PaW-1:0]      physical_address;
		logic                fault;
	} walk_result_t;

	function automatic logic [IdxW-1:0] level_index(input logic [VaW-1:0] va, input level_t lvl);
		logic [IdxW-1:0] idx;
		unique case (lvl)
			LVL_TOP:    idx = va[47:39];
			LVL_SECOND: idx = va[38:30];
			LVL_THIRD:  idx = va[29:21];
			LVL_LAST:   idx = va[20:12];
			default:    idx = '0;
		endcase
		return idx;
	endfunction

	function automatic logic [AddrW-1:0] entry_offset(input logic [IdxW-1:0] idx);
		return {{(AddrW-IdxW-3){1'b0}}, idx, 3'b000};
	endfunction

endpackage

`default_nettype wire

### rtl/core/ptw_step.sv
// Combinational step of the walk: one start or one returned entry per item.
`timescale 1ns / 1ps
`default_nettype none

module ptw_step
	import ptw_pkg::*;
(
	input  walk_item_t   item,
	input  walk_state_t  state,
	output walk_state_t  state_next,
	output logic         has_result,
	output walk_result_t result
);

	logic [AddrW-1:0] entry;
	logic [AddrW-1:0] frame;
	logic [AddrW-1:0] next_addr;
	level_t           next_lvl;
	logic             finish;
	logic             fail;
	logic [PaW-1:0]   pa;

	assign entry     = item.read_data;
	assign frame     = {28'b0, entry[35:12], 12'b0};
	assign next_lvl  = level_t'(2'(state.level) + 2'd1);
	assign next_addr = frame + entry_offset(level_index(state.saved_address, next_lvl));

	always_comb begin
		finish = 1'b0;
		fail   = 1'b0;
		pa     = '0;
		unique case (state.level)
			LVL_TOP: begin
				fail   = !entry[PresentBit];
				finish = fail;
			end
			LVL_SECOND: begin
				if (!entry[PresentBit]) begin
					fail   = 1'b1;
					finish = 1'b1;
				end else if (entry[PageSizeBit]) begin
					finish = 1'b1;
					pa     = {entry[51:30], state.saved_address[29:0]};
				end
			end
			LVL_THIRD: begin
				if (!entry[PresentBit]) begin
					fail   = 1'b1;
					finish = 1'b1;
				end else if (entry[PageSizeBit]) begin
					finish = 1'b1;
					pa     = {16'b0, entry[35:21], state.saved_address[20:0]};
				end
			end
			LVL_LAST: begin
				finish = 1'b1;
				fail   = (entry[35:12] == 24'd0);
				pa     = {16'b0, entry[35:12], state.saved_address[11:0]};
			end
			default: begin
				finish = 1'b0;
			end
		endcase
	end

	always_comb begin
		state_next = state;
		has_result = 1'b0;
		result     = '0;
		if (item.opcode == OP_START) begin
			state_next.busy          = 1'b1;
			state_next.level         = LVL_TOP;
			state_next.saved_address = item.virtual_address;
			has_result               = 1'b1;
			result.kind              = KIND_READ;
			result.read_address      = {item.root_base[AddrW-1:4], 4'b0000}
				+ entry_offset(level_index(item.virtual_address, LVL_TOP));
		end else if (state.busy) begin
			has_result = 1'b1;
			if (finish) begin
				state_next.busy         = 1'b0;
				state_next.level        = LVL_TOP;
				result.kind             = KIND_DONE;
				result.fault            = fail;
				result.physical_address = fail ? '0 : pa;
			end else begin
				state_next.level    = next_lvl;
				result.kind         = KIND_READ;
				result.read_address = next_addr;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/ptw_out_reg.sv
// Result register that holds one result until the output transfer.
`timescale 1ns / 1ps
`default_nettype none

module ptw_out_reg
	import ptw_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  walk_result_t load_result,
	input  logic         out_ready,
	output logic         out_valid,
	output logic         can_load,
	output walk_result_t result
);

	logic         valid_q;
	walk_result_t result_q;

	assign can_load  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign result    = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			result_q <= load_result;
		end
	end

endmodule

`default_nettype wire

### rtl/core/four_level_page_table_walker.sv
// Top level of the four-level page table walker.
// An accepted item waits in the input register; any result it has is then loaded into the output register.
// Throughput: one item per cycle while the output is free; otherwise the input register holds one more item.
// Each item passes one combinational step between the input register and the result register.
// Reset clears the walk state (idle, top level, zero address) and both valid flags.
`timescale 1ns / 1ps
`default_nettype none
`include "four_level_page_table_walker_assert.svh"

module four_level_page_table_walker
	import ptw_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             opcode,
	input  logic [AddrW-1:0] root_base,
	input  logic [VaW-1:0]   virtual_address,
	input  logic [AddrW-1:0] read_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             kind,
	output logic [AddrW-1:0] read_address,
	output logic [PaW-1:0]   physical_address,
	output logic             fault
);

	logic         valid_s1;
	walk_item_t   item_s1;
	walk_state_t  state_q;
	walk_state_t  state_next;
	logic         has_result;
	walk_result_t step_result;
	walk_result_t out_result;
	logic         out_free;
	logic         advance;

	assign advance  = valid_s1 && (!has_result || out_free);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.opcode          <= opcode_t'(opcode);
			item_s1.root_base       <= root_base;
			item_s1.virtual_address <= virtual_address;
			item_s1.read_data       <= read_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.busy          <= 1'b0;
			state_q.level         <= LVL_TOP;
			state_q.saved_address <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	ptw_step u_step (
		.item       (item_s1),
		.state      (state_q),
		.state_next (state_next),
		.has_result (has_result),
		.result     (step_result)
	);

	ptw_out_reg u_out_reg (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (advance && has_result),
		.load_result (step_result),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.can_load    (out_free),
		.result      (out_result)
	);

	assign kind             = out_result.kind;
	assign read_address     = out_result.read_address;
	assign physical_address = out_result.physical_address;
	assign fault            = out_result.fault;

	`PTW_ASSERT_IMP(a_done_no_addr, clk, arst_n,
		out_valid && (out_result.kind == KIND_DONE), read_address == '0,
		"finished walk carries a read address")
	`PTW_ASSERT_IMP(a_fault_is_done, clk, arst_n,
		out_valid && fault, (out_result.kind == KIND_DONE) && (physical_address == '0),
		"fault on a read request or with a nonzero physical address")
	`PTW_ASSERT_IMP(a_read_aligned, clk, arst_n,
		out_valid && (out_result.kind == KIND_READ), read_address[2:0] == 3'b000,
		"entry read address is not 8-byte aligned")
	`PTW_ASSERT_NXT(a_done_goes_idle, clk, arst_n,
		advance && has_result && (step_result.kind == KIND_DONE), !state_q.busy,
		"walker still busy after a finished walk")

endmodule

`default_nettype wire

### tb/four_level_page_table_walker_checker.sv
// Checker that predicts page table walker results from accepted transfers and compares them.
`timescale 1ns / 1ps

module four_level_page_table_walker_checker
	import ptw_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	input  logic             opcode,
	input  logic [AddrW-1:0] root_base,
	input  logic [VaW-1:0]   virtual_address,
	input  logic [AddrW-1:0] read_data,
	input  logic             out_valid,
	input  logic             out_ready,
	input  logic             kind,
	input  logic [AddrW-1:0] read_address,
	input  logic [PaW-1:0]   physical_address,
	input  logic             fault,
	output int               failures,
	output int               pending
);

	logic           walking;
	level_t         depth;
	logic [VaW-1:0] latched_va;
	walk_result_t   expected_q[$];

	function automatic logic [AddrW-1:0] table_slot(input logic [AddrW-1:0] base,
		input level_t lvl);
		logic [IdxW-1:0] idx;
		idx = IdxW'(latched_va >> (39 - 9 * int'(lvl)));
		return base + {idx, 3'b000};
	endfunction

	function automatic walk_result_t read_request(input logic [AddrW-1:0] addr);
		walk_result_t r;
		r.kind = KIND_READ;
		r.read_address = addr;
		r.physical_address = '0;
		r.fault = 1'b0;
		return r;
	endfunction

	function automatic walk_result_t finish_walk(input logic [PaW-1:0] pa, input logic failed);
		walk_result_t r;
		walking = 1'b0;
		depth = LVL_TOP;
		r.kind = KIND_DONE;
		r.read_address = '0;
		r.physical_address = failed ? '0 : pa;
		r.fault = failed;
		return r;
	endfunction

	function automatic walk_result_t descend(input logic [AddrW-1:0] entry);
		depth = level_t'(depth + 2'd1);
		return read_request(table_slot({28'b0, entry[35:12], 12'b0}, depth));
	endfunction

	function automatic bit translate_step(input opcode_t op, input logic [AddrW-1:0] base,
		input logic [VaW-1:0] va, input logic [AddrW-1:0] entry, output walk_result_t r);
		r = '0;
		if (op == OP_START) begin
			walking = 1'b1;
			depth = LVL_TOP;
			latched_va = va;
			r = read_request(table_slot({base[AddrW-1:4], 4'b0000}, LVL_TOP));
			return 1'b1;
		end
		if (!walking)
			return 1'b0;
		case (depth)
			LVL_TOP: begin
				if (!entry[PresentBit])
					r = finish_walk('0, 1'b1);
				else
					r = descend(entry);
			end
			LVL_SECOND: begin
				if (!entry[PresentBit])
					r = finish_walk('0, 1'b1);
				else if (entry[PageSizeBit])
					r = finish_walk({entry[51:30], latched_va[29:0]}, 1'b0);
				else
					r = descend(entry);
			end
			LVL_THIRD: begin
				if (!entry[PresentBit])
					r = finish_walk('0, 1'b1);
				else if (entry[PageSizeBit])
					r = finish_walk({16'b0, entry[35:21], latched_va[20:0]}, 1'b0);
				else
					r = descend(entry);
			end
			default: begin
				if (entry[35:12] == '0)
					r = finish_walk('0, 1'b1);
				else
					r = finish_walk({16'b0, entry[35:12], latched_va[11:0]}, 1'b0);
			end
		endcase
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		walk_result_t want;
		walk_result_t got;
		if (!arst_n) begin
			walking = 1'b0;
			depth = LVL_TOP;
			latched_va = '0;
			expected_q.delete();
			failures = 0;
			pending = 0;
		end else begin
			if (in_valid && in_ready &&
				translate_step(opcode_t'(opcode), root_base, virtual_address, read_data, want))
				expected_q.push_back(want);
			if (out_valid && out_ready) begin
				got.kind = kind_t'(kind);
				got.read_address = read_address;
				got.physical_address = physical_address;
				got.fault = fault;
				if (expected_q.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("%0t: unexpected result kind=%0d read_address=%h pa=%h fault=%0d",
							$realtime, got.kind, got.read_address, got.physical_address,
							got.fault);
				end else begin
					want = expected_q.pop_front();
					if (got.kind !== want.kind || got.read_address !== want.read_address ||
						got.physical_address !== want.physical_address ||
						got.fault !== want.fault) begin
						failures++;
						if (failures <= 10) begin
							$display("%0t: mismatch, expected kind=%0d read_address=%h pa=%h fault=%0d",
								$realtime, want.kind, want.read_address, want.physical_address,
								want.fault);
							$display("%0t:           actual kind=%0d read_address=%h pa=%h fault=%0d",
								$realtime, got.kind, got.read_address, got.physical_address,
								got.fault);
						end
					end
				end
			end
			pending = expected_q.size();
		end
	end

endmodule

### tb/four_level_page_table_walker_tb.sv
// Testbench top that drives walks into the page table walker and reports the verdict.
`timescale 1ns / 1ps

module four_level_page_table_walker_tb;
	import ptw_pkg::*;

	localparam int StallLimit = 1000;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic             opcode = 1'b0;
	logic [AddrW-1:0] root_base = '0;
	logic [VaW-1:0]   virtual_address = '0;
	logic [AddrW-1:0] read_data = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic             kind;
	logic [AddrW-1:0] read_address;
	logic [PaW-1:0]   physical_address;
	logic             fault;
	int               failures;
	int               pending;

	int               walk_items = 0;
	int               quiet_cycles = 0;
	bit               calm = 1'b0;

	four_level_page_table_walker i_dut (.*);

	four_level_page_table_walker_checker i_checker (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [AddrW-1:0] any64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [AddrW-1:0] table_entry();
		logic [AddrW-1:0] e;
		e = any64();
		e[PresentBit] = 1'b1;
		e[PageSizeBit] = 1'b0;
		return e;
	endfunction

	function automatic logic [AddrW-1:0] leaf_entry();
		logic [AddrW-1:0] e;
		e = any64();
		e[PresentBit] = 1'b1;
		e[PageSizeBit] = 1'b1;
		return e;
	endfunction

	function automatic logic [AddrW-1:0] absent_entry();
		logic [AddrW-1:0] e;
		e = any64();
		e[PresentBit] = 1'b0;
		return e;
	endfunction

	function automatic logic [AddrW-1:0] empty_frame();
		logic [AddrW-1:0] e;
		e = any64();
		e[35:12] = '0;
		return e;
	endfunction

	task automatic offer(input opcode_t op, input logic [AddrW-1:0] base,
		input logic [VaW-1:0] va, input logic [AddrW-1:0] entry);
		while (!calm && $urandom_range(99) < 22) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		root_base <= base;
		virtual_address <= va;
		read_data <= entry;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic start_walk(input logic [AddrW-1:0] base, input logic [VaW-1:0] va);
		offer(OP_START, base, va, any64());
	endtask

	task automatic reply(input logic [AddrW-1:0] entry);
		offer(OP_DATA, any64(), VaW'(any64()), entry);
	endtask

	task automatic random_walk();
		logic [AddrW-1:0] base;
		logic [VaW-1:0]   va;
		int               roll;
		base = any64();
		va = VaW'(any64());
		roll = $urandom_range(15);
		if (roll == 0)
			base = '1;
		else if (roll == 1)
			base = '0;
		roll = $urandom_range(15);
		if (roll == 0)
			va = '1;
		else if (roll == 1)
			va = '0;
		start_walk(base, va);
		walk_items++;
		for (int lvl = 0; lvl < 4; lvl++) begin
			roll = $urandom_range(99);
			if (roll < 5)
				return;
			walk_items++;
			if (lvl == 3) begin
				reply(roll < 13 ? empty_frame() : any64());
				return;
			end
			if (roll < 13) begin
				reply(absent_entry());
				return;
			end
			if (lvl > 0 && roll < 30) begin
				reply(leaf_entry());
				return;
			end
			reply(lvl == 0 ? (any64() | 64'h1) : table_entry());
		end
	endtask

	task automatic noise_burst();
		int count;
		count = $urandom_range(3, 1);
		repeat (count)
			offer(opcode_t'($urandom_range(1)), any64(), VaW'(any64()), any64());
	endtask

	initial begin
		int               cycle_count;
		int               hold;
		cycle_count = 0;
		hold = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count == 200 || cycle_count == 800)
				hold = 60;
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else if (cycle_count >= 400 && cycle_count < 700) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= 22);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= StallLimit) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		logic [AddrW-1:0] e;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Data with no walk in progress must be dropped.
		reply('1);

		// Extreme root and address, then a last level entry whose frame is zero.
		start_walk('1, '1);
		reply('1);
		reply(64'hFFFF_FFFF_FFFF_FF7F);
		reply(64'hFFFF_FFFF_FFFF_FF7F);
		reply(64'hFFFF_FFF0_0000_0FFF);

		start_walk('0, '0);
		reply(64'h0);

		start_walk(any64(), VaW'(any64()));
		reply(table_entry());
		reply(absent_entry());

		start_walk(any64(), VaW'(any64()));
		reply(table_entry());
		reply(table_entry());
		reply(absent_entry());

		start_walk(any64(), VaW'(any64()));
		reply(table_entry());
		reply(table_entry());
		reply(leaf_entry());

		start_walk(any64(), '1);
		reply(table_entry());
		reply('1);

		// A new start drops the walk in progress; the last entry has no present bit.
		start_walk(any64(), VaW'(any64()));
		reply(table_entry());
		start_walk(any64(), VaW'(any64()));
		reply(table_entry());
		reply(table_entry());
		reply(table_entry());
		e = absent_entry();
		e[12] = 1'b1;
		reply(e);

		while (walk_items < 600) begin
			calm = (walk_items >= 250 && walk_items < 400);
			if ($urandom_range(99) < 8)
				noise_burst();
			else
				random_walk();
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
